### rtl/evest_pkg.sv
// Shared constants, widths and controller/datapath interface types for the
// encoder velocity estimator. No dependencies.
package evest_pkg;

  localparam int CHANNELS  = 2;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CNT_W     = 16;
  localparam int TIME_W    = 32;
  localparam int RATE_W    = 20;
  localparam int LIMIT_W   = 16;
  localparam int MINIV_W   = 16;
  localparam int VEL_W     = 15;
  localparam int HELD_W    = 17;

  localparam int LHS_W     = CNT_W + RATE_W;
  localparam int RHS_W     = LIMIT_W + TIME_W;
  localparam int QUO_W     = LIMIT_W;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  // register map, one word per register
  typedef enum logic [1:0] {
    REG_SPIKE_LIMIT  = 2'd0,
    REG_TICK_RATE    = 2'd1,
    REG_MIN_INTERVAL = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] spike_limit;
    logic [RATE_W-1:0]  tick_rate;
    logic [MINIV_W-1:0] min_interval;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic decide;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pass;
    logic out_free;
  } sts_t;

endpackage

### rtl/evest_regs.sv
// APB configuration registers: spike limit, tick rate, minimum interval.
// Depends on evest_pkg.
module evest_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output evest_pkg::cfg_t   cfg_o
);
  import evest_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_SPIKE_LIMIT:  cfg_d.spike_limit  = pwdata[LIMIT_W-1:0];
        REG_TICK_RATE:    cfg_d.tick_rate    = pwdata[RATE_W-1:0];
        REG_MIN_INTERVAL: cfg_d.min_interval = pwdata[MINIV_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPIKE_LIMIT:  prdata = 32'(cfg_q.spike_limit);
      REG_TICK_RATE:    prdata = 32'(cfg_q.tick_rate);
      REG_MIN_INTERVAL: prdata = 32'(cfg_q.min_interval);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spike_limit  <= LIMIT_W'(15000);
      cfg_q.tick_rate    <= RATE_W'(1000);
      cfg_q.min_interval <= MINIV_W'(2);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/evest_ctrl.sv
// Sequencing controller: accept, multiply, decide, divide, deliver.
// Depends on evest_pkg.
module evest_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  evest_pkg::sts_t sts_i,
  output evest_pkg::cmd_t cmd_o
);
  import evest_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.decide = 1'b1;
        step_d       = '0;
        state_d      = sts_i.pass ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + DIV_CNT_W'(1);
        if (step_q == DIV_CNT_W'(QUO_W - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

### rtl/evest_dp.sv
// Datapath: per-channel history, products, spike compare, radix-2 divider
// and output register. Depends on evest_pkg.
module evest_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  evest_pkg::cfg_t       cfg_i,
  input  evest_pkg::cmd_t       cmd_i,
  output evest_pkg::sts_t       sts_o,
  input  logic                  in_channel_i,
  input  logic [15:0]           in_count_i,
  input  logic [31:0]           in_timestamp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [14:0]    out_velocity_o,
  output logic                  out_fresh_o
);
  import evest_pkg::*;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [HELD_W-1:0] v);
    logic signed [HELD_W-1:0] hi;
    logic signed [HELD_W-1:0] lo;
    hi = HELD_W'((1 << (VEL_W - 1)) - 1);
    lo = -HELD_W'(1 << (VEL_W - 1));
    if (v > hi)      sat_vel = VEL_W'(hi);
    else if (v < lo) sat_vel = VEL_W'(lo);
    else             sat_vel = VEL_W'(v);
  endfunction

  logic [CNT_W-1:0]         last_count_q [CHANNELS];
  logic [TIME_W-1:0]        last_time_q  [CHANNELS];
  logic signed [HELD_W-1:0] held_q       [CHANNELS];

  logic [CH_IDX_W-1:0] in_idx, ch_q;
  logic [CNT_W-1:0]    lc;
  logic [TIME_W-1:0]   interval_d, interval_q;
  logic [MINIV_W-1:0]  min_iv;
  logic [CNT_W-1:0]    mag_q;
  logic                neg_q, long_q, pass_q;
  logic [LHS_W-1:0]    lhs_q;
  logic [RHS_W-1:0]    rhs_q;
  logic [TIME_W-1:0]   rem_q;
  logic [QUO_W-1:0]    dvd_q;
  logic [TIME_W:0]     trial;
  logic                ge;
  logic                pass;
  logic signed [HELD_W-1:0] new_v, vsel;
  logic                out_valid_q;
  logic signed [VEL_W-1:0] out_vel_q;
  logic                out_fresh_q;

  // Clamp the channel into the populated range
  assign in_idx = (32'(in_channel_i) >= CHANNELS) ? CH_IDX_W'(CHANNELS - 1)
                                                 : CH_IDX_W'(in_channel_i);
  assign lc         = last_count_q[in_idx];
  assign interval_d = in_timestamp_i - last_time_q[in_idx];
  assign min_iv     = (cfg_i.min_interval == '0) ? MINIV_W'(1) : cfg_i.min_interval;

  assign pass = long_q && (RHS_W'(lhs_q) <= rhs_q);

  assign trial = {rem_q, dvd_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, interval_q};

  assign new_v = neg_q ? -$signed(HELD_W'(dvd_q)) : $signed(HELD_W'(dvd_q));
  assign vsel  = pass_q ? new_v : held_q[ch_q];

  assign sts_o.pass     = pass;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_velocity_o = out_vel_q;
  assign out_fresh_o    = out_fresh_q;

  // Payload working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q       <= in_idx;
      interval_q <= interval_d;
      neg_q      <= in_count_i < lc;
      mag_q      <= (in_count_i < lc) ? (lc - in_count_i) : (in_count_i - lc);
      long_q     <= interval_d >= TIME_W'(min_iv);
    end
    if (cmd_i.mul) begin
      lhs_q <= LHS_W'(mag_q) * LHS_W'(cfg_i.tick_rate);
      rhs_q <= RHS_W'(cfg_i.spike_limit) * RHS_W'(interval_q);
    end
    if (cmd_i.decide) begin
      pass_q <= pass;
      // Quotient fits in QUO_W bits, so the upper part starts below the divisor
      rem_q  <= TIME_W'(lhs_q >> QUO_W);
      dvd_q  <= lhs_q[QUO_W-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? TIME_W'(trial - {1'b0, interval_q}) : trial[TIME_W-1:0];
      dvd_q <= {dvd_q[QUO_W-2:0], ge};
    end
    if (cmd_i.finish) begin
      out_vel_q   <= sat_vel(vsel);
      out_fresh_q <= pass_q;
    end
  end

  // Channel history and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_count_q[i] <= '0;
        last_time_q[i]  <= '0;
        held_q[i]       <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        last_count_q[in_idx] <= in_count_i;
        last_time_q[in_idx]  <= in_timestamp_i;
      end
      if (cmd_i.finish && pass_q) held_q[ch_q] <= new_v;
      if (cmd_i.finish)      out_valid_q <= 1'b1;
      else if (out_ready_i)  out_valid_q <= 1'b0;
    end
  end

endmodule

### rtl/encoder_velocity_estimator.sv
// Encoder velocity estimator top level; depends on evest_pkg, evest_regs, evest_ctrl, evest_dp.
// Sequence per sample: capture, multiply, decide, then either deliver the held velocity
// or run the 16 steps of the radix-2 divider before delivering a fresh velocity.
// Only one sample is in flight at a time; a waiting result delays only the delivery
// step. Reset (rst_ni, asynchronous, active low) clears the channel history and held
// velocities to zero and loads the register defaults.
module encoder_velocity_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [15:0] count, [47:16] timestamp
  input  logic        s_axis_tuser_i,   // [0] channel
  // velocity stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [14:0] velocity (signed), [15] zero
  output logic        m_axis_tuser_o,   // [0] fresh
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import evest_pkg::*;

  cfg_t                    cfg;
  cmd_t                    cmd;
  sts_t                    sts;
  logic signed [VEL_W-1:0] vel;

  // Register file; the user must write it only while idle (not enforced here), so the datapath reads it directly
  evest_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: one sample in flight, ready only in its idle state
  evest_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic, history and the output register that decouples the result side
  evest_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_channel_i   (s_axis_tuser_i),
    .in_count_i     (s_axis_tdata_i[15:0]),
    .in_timestamp_i (s_axis_tdata_i[47:16]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_velocity_o (vel),
    .out_fresh_o    (m_axis_tuser_o)
  );

  // Pad velocity to a 16-bit word
  assign m_axis_tdata_o = {1'b0, vel};

endmodule

### rtl/evest_chk.sv
// Port-level checker for the encoder velocity estimator, bound to the top level.
// No package dependency.
module evest_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

  // One sample in flight: no second beat straight after an accepted one
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready_o)
    else $error("input ready straight after a sample beat");

  // A new result appears only out of a busy period
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result raised without work in progress");

  // The multiply and decide states lie between an accepted sample and the rise of its result
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> ##1 !$rose(m_axis_tvalid_o) ##1 !$rose(m_axis_tvalid_o))
    else $error("result delivered too early");

endmodule

bind encoder_velocity_estimator evest_chk u_evest_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
